// ===== rtl/core/bds_pkg.sv =====
// Shared types and constants of the 4x4 box downscaler.
// Used by every module in rtl/core; depends on nothing.
`default_nettype none
package bds_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int SIZE_W      = 13;
	localparam int POS_W       = 12;
	localparam int PART_W      = 18;
	localparam int SUM_W       = 20;
	localparam int NUM_COLS    = 1024;
	localparam int COL_W       = 10;
	localparam int MUL_W       = 21;
	localparam int RECIP_SHIFT = 24;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	localparam logic [SIZE_W-1:0] SIZE_MIN   = 13'd4;
	localparam logic [SIZE_W-1:0] SIZE_MAX   = 13'd4096;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd1024;

	// Reciprocals scaled by 2^24; exact for every sum below 2^21.
	localparam logic [MUL_W-1:0] RECIP_16 = 21'd1048576;
	localparam logic [MUL_W-1:0] RECIP_12 = 21'd1398102;
	localparam logic [MUL_W-1:0] RECIP_9  = 21'd1864136;

	localparam logic [2:0] ADDR_FRAME_SIZE = 3'd0;

	typedef enum logic [1:0] {
		DIV_16,
		DIV_12,
		DIV_9
	} div_sel_t;

	typedef struct packed {
		logic             valid;
		logic [SUM_W-1:0] sum;
		div_sel_t         div;
		logic             last;
	} blk_t;

endpackage
`default_nettype wire

// ===== rtl/core/bds_accum.sv =====
// Raster position tracking, row segment sums and the per-column block sum memory.
// Depends on bds_pkg.
`default_nettype none
module bds_accum (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          restart,
	input  wire logic [bds_pkg::SIZE_W-1:0]    frame_size,
	input  wire logic                          in_take,
	input  wire logic [bds_pkg::SAMPLE_W-1:0]  sample,
	output bds_pkg::blk_t                      blk,
	output logic                               emit_pend
);

	logic [bds_pkg::SIZE_W-1:0]  size;
	logic [bds_pkg::SIZE_W-1:0]  size_m1_full;
	logic [bds_pkg::POS_W-1:0]   size_m1;
	logic [bds_pkg::COL_W:0]     nb;
	logic [bds_pkg::COL_W:0]     nb_m1;
	logic [bds_pkg::POS_W-1:0]   col_q;
	logic [bds_pkg::POS_W-1:0]   row_q;
	logic [bds_pkg::PART_W-1:0]  part_q;
	logic [bds_pkg::PART_W-1:0]  part_next;
	logic [bds_pkg::COL_W-1:0]   bc;
	logic [bds_pkg::COL_W-1:0]   br;
	logic                        in_blk;
	logic                        incl;
	logic                        rd_en;
	logic                        col_short;
	logic                        row_short;
	bds_pkg::div_sel_t           div_sel;

	logic [bds_pkg::SUM_W-1:0]   mem [bds_pkg::NUM_COLS];
	logic [bds_pkg::SUM_W-1:0]   mem_rd_q;

	logic                        valid_s1;
	logic                        emit_s1;
	logic                        first_s1;
	logic                        last_s1;
	logic [bds_pkg::COL_W-1:0]   idx_s1;
	logic [bds_pkg::PART_W-1:0]  part_s1;
	bds_pkg::div_sel_t           div_s1;
	logic [bds_pkg::SUM_W-1:0]   new_sum;

	always_comb begin
		if (frame_size < bds_pkg::SIZE_MIN) begin
			size = bds_pkg::SIZE_MIN;
		end else if (frame_size > bds_pkg::SIZE_MAX) begin
			size = bds_pkg::SIZE_MAX;
		end else begin
			size = frame_size;
		end
	end

	assign size_m1_full = size - 13'd1;
	assign size_m1      = size_m1_full[bds_pkg::POS_W-1:0];
	assign nb           = size[bds_pkg::SIZE_W-1:2];
	assign nb_m1        = nb - 11'd1;
	assign bc           = col_q[bds_pkg::POS_W-1:2];
	assign br           = row_q[bds_pkg::POS_W-1:2];
	assign in_blk       = ({1'b0, bc} < nb) && ({1'b0, br} < nb);
	assign incl         = (col_q < size_m1) && (row_q < size_m1);
	assign rd_en        = in_take && in_blk && (col_q[1:0] == 2'd3);
	// The last block column or row loses its fourth sample when it touches index size-1.
	assign col_short    = ({bc, 2'b11} == size_m1);
	assign row_short    = ({br, 2'b11} == size_m1);

	always_comb begin
		part_next = (col_q[1:0] == 2'd0) ? '0 : part_q;
		if (incl) begin
			part_next = part_next + {2'b00, sample};
		end
		if (col_short && row_short) begin
			div_sel = bds_pkg::DIV_9;
		end else if (col_short || row_short) begin
			div_sel = bds_pkg::DIV_12;
		end else begin
			div_sel = bds_pkg::DIV_16;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			part_q <= '0;
		end else if (restart) begin
			col_q  <= '0;
			row_q  <= '0;
			part_q <= '0;
		end else if (in_take) begin
			if (in_blk) begin
				part_q <= part_next;
			end
			if (col_q == size_m1) begin
				col_q <= '0;
				row_q <= (row_q == size_m1) ? '0 : row_q + 12'd1;
			end else begin
				col_q <= col_q + 12'd1;
			end
		end
	end

	// Read the column sum as the segment closes; add and write back in the next cycle.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			mem_rd_q <= mem[bc];
		end
		if (valid_s1) begin
			mem[idx_s1] <= new_sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			emit_s1  <= 1'b0;
		end else begin
			valid_s1 <= rd_en;
			emit_s1  <= rd_en && (row_q[1:0] == 2'd3);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			idx_s1   <= bc;
			part_s1  <= part_next;
			first_s1 <= (row_q[1:0] == 2'd0);
			last_s1  <= ({1'b0, bc} == nb_m1) && ({1'b0, br} == nb_m1);
			div_s1   <= div_sel;
		end
	end

	assign new_sum = first_s1 ? {2'b00, part_s1} : mem_rd_q + {2'b00, part_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk <= '0;
		end else begin
			blk.valid <= valid_s1 && emit_s1;
			if (valid_s1 && emit_s1) begin
				blk.sum  <= new_sum;
				blk.div  <= div_s1;
				blk.last <= last_s1;
			end
		end
	end

	assign emit_pend = valid_s1 && emit_s1;

`ifndef ASSERT_OFF
	a_no_rmw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && valid_s1 && (bc == idx_s1)))
		else $error("column sum read while its write-back is pending");
	a_blk_from_rmw: assert property (@(posedge clk) disable iff (!arst_n)
		blk.valid |-> $past(valid_s1))
		else $error("block result without a column update");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/bds_divide.sv =====
// Divides a block sum by 16, 12 or 9 through a scaled reciprocal product.
// Depends on bds_pkg.
`default_nettype none
module bds_divide (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire bds_pkg::blk_t                 blk,
	output logic                               res_valid,
	output logic [bds_pkg::SAMPLE_W-1:0]       res_avg,
	output logic                               res_last
);

	logic [bds_pkg::MUL_W-1:0]                 recip;
	logic [bds_pkg::SUM_W+bds_pkg::MUL_W-1:0]  prod;

	always_comb begin
		case (blk.div)
			bds_pkg::DIV_16: recip = bds_pkg::RECIP_16;
			bds_pkg::DIV_12: recip = bds_pkg::RECIP_12;
			bds_pkg::DIV_9:  recip = bds_pkg::RECIP_9;
			default:         recip = bds_pkg::RECIP_16;
		endcase
	end

	assign prod = {{bds_pkg::MUL_W{1'b0}}, blk.sum} * {{bds_pkg::SUM_W{1'b0}}, recip};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else begin
			res_valid <= blk.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (blk.valid) begin
			res_avg  <= prod[bds_pkg::RECIP_SHIFT +: bds_pkg::SAMPLE_W];
			res_last <= blk.last;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/bds_outq.sv =====
// Small result queue that decouples the output stream from the sample pipeline.
// Depends on bds_pkg.
`default_nettype none
module bds_outq (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	input  wire logic [bds_pkg::SAMPLE_W-1:0]  push_avg,
	input  wire logic                          push_last,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [bds_pkg::SAMPLE_W-1:0]       out_avg,
	output logic                               out_last,
	output logic [bds_pkg::QCNT_W-1:0]         count
);

	logic [bds_pkg::SAMPLE_W:0]   entry [bds_pkg::QUEUE_DEPTH];
	logic [bds_pkg::QPTR_W-1:0]   head_q;
	logic [bds_pkg::QPTR_W-1:0]   tail_q;
	logic [bds_pkg::QCNT_W-1:0]   count_q;
	logic                         pop;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid && out_ready;
	assign out_avg   = entry[head_q][bds_pkg::SAMPLE_W-1:0];
	assign out_last  = entry[head_q][bds_pkg::SAMPLE_W];
	assign count     = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entry[tail_q] <= {push_last, push_avg};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				tail_q <= tail_q + 2'd1;
			end
			if (pop) begin
				head_q <= head_q + 2'd1;
			end
			if (push && !pop) begin
				count_q <= count_q + 3'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 3'd1;
			end
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < 3'(bds_pkg::QUEUE_DEPTH)) || pop)
		else $error("result queue overflow");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 3'(bds_pkg::QUEUE_DEPTH))
		else $error("result queue count out of range");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/box_downscale_4x4.sv =====
// Top level of the 4x4 box downscaler: register port, credit check and stream ports.
// Depends on bds_pkg, bds_accum, bds_divide and bds_outq.
//
// Channel    | Direction | Word                              | Handshake
// samples    | in        | s_tdata[15:0] height_sample       | s_tvalid / s_tready
// results    | out       | m_tdata[15:0] block_average,      | m_tvalid / m_tready
//            |           | m_tlast last_of_frame             |
// config     | in        | frame_size at byte address 0      | APB write, pready tied high
//
// One sample word is taken per cycle while s_tready is high. A block result is produced in
// steps: the column sum is read at the edge that takes the sample at its lower-right corner,
// then the sum is written back, multiplied by the reciprocal and queued.
// The column sum memory does one read-modify-write per four samples, so it never limits
// the rate.
// Reset needs no clearing pass: each column sum is overwritten on the first row of a block
// row, where the value read is not used. s_tready drops only when queued plus in-flight
// results reach four, i.e. when the output side has stalled for several results.
`default_nettype none
module box_downscale_4x4 (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// config port
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	// sample stream
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [15:0]  s_tdata,   // [15:0] height_sample
	// result stream
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [15:0]       m_tdata,   // [15:0] block_average
	output logic              m_tlast    // last_of_frame
);

	logic [bds_pkg::SIZE_W-1:0]    frame_size_q;
	logic                          cfg_wr;
	logic                          in_take;
	bds_pkg::blk_t                 blk;
	logic                          emit_pend;
	logic                          res_valid;
	logic [bds_pkg::SAMPLE_W-1:0]  res_avg;
	logic                          res_last;
	logic [bds_pkg::QCNT_W-1:0]    q_count;
	logic [bds_pkg::QCNT_W-1:0]    owed;

	// Register file: one register, reads return it zero-extended.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == bds_pkg::ADDR_FRAME_SIZE[2]);
	assign prdata = (paddr[2] == bds_pkg::ADDR_FRAME_SIZE[2]) ?
		{{(32-bds_pkg::SIZE_W){1'b0}}, frame_size_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_size_q <= bds_pkg::SIZE_RESET;
		end else if (cfg_wr) begin
			frame_size_q <= pwdata[bds_pkg::SIZE_W-1:0];
		end
	end

	// Credit check: hold off input until the queue has room for every result that
	// may still land in it, including one from the word about to be taken.
	assign owed = q_count + {2'b00, emit_pend} + {2'b00, blk.valid} + {2'b00, res_valid};
	assign s_tready = (owed < 3'(bds_pkg::QUEUE_DEPTH));
	assign in_take  = s_tvalid && s_tready;

	bds_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.restart    (cfg_wr),
		.frame_size (frame_size_q),
		.in_take    (in_take),
		.sample     (s_tdata),
		.blk        (blk),
		.emit_pend  (emit_pend)
	);

	bds_divide u_divide (
		.clk       (clk),
		.arst_n    (arst_n),
		.blk       (blk),
		.res_valid (res_valid),
		.res_avg   (res_avg),
		.res_last  (res_last)
	);

	bds_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_avg  (res_avg),
		.push_last (res_last),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_avg   (m_tdata),
		.out_last  (m_tlast),
		.count     (q_count)
	);

`ifndef ASSERT_OFF
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		owed <= 3'(bds_pkg::QUEUE_DEPTH))
		else $error("more results owed than queue slots");
`endif

endmodule
`default_nettype wire
